// ===== sv/dqe_pkg.sv =====
`default_nettype none
package dqe_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;
  localparam int KIND_W   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one-hot at most; all zero when nothing moves this cycle
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/double_ended_queue.sv =====
// An accepted operation's result reaches the out_ port in the next cycle.
// Throughput: one operation per cycle while out_ready is high or no result
// is pending; push_front and pop_front shift the whole chain at once.
// Reset (rst_n, synchronous, active low) empties the queue and drops any
// pending result; stored words are not cleared.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH      = dqe_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [dqe_pkg::KIND_W-1:0]   in_kind,
  input  wire logic signed [dqe_pkg::VALUE_W-1:0]  in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed      [dqe_pkg::VALUE_W-1:0]  out_popped_value,
  output logic             [dqe_pkg::STATUS_W-1:0] out_status,
  output logic             [dqe_pkg::FILL_W-1:0]   out_fill_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tail [DEPTH];
  logic [DEPTH-1:0]      cell_valid;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] back_word;
  logic [DATA_WIDTH-1:0] pop_word;

  dqe_pkg::cell_ctl_t ctl;
  dqe_pkg::status_t   status;
  logic               accept;
  logic               full;
  logic               empty;

  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [dqe_pkg::VALUE_W-1:0]     pop_r, pop_nxt;
  logic [dqe_pkg::STATUS_W-1:0]    status_r;
  logic [dqe_pkg::FILL_W-1:0]      fill_r;

  assign in_ready = out_ready || !out_valid_r;
  assign accept   = in_valid && in_ready;
  assign full     = cell_valid[DEPTH-1];
  assign empty    = !cell_valid[0];
  assign word     = DATA_WIDTH'(in_value);

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_word = back_word | cell_tail[i];
    end
  end

  always_comb begin
    ctl      = '0;
    status   = dqe_pkg::ST_DONE;
    cnt_nxt  = cnt_r;
    pop_word = '0;
    case (in_kind)
      dqe_pkg::KIND_PUSH_FRONT,
      dqe_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          status = dqe_pkg::ST_FULL;
        end else begin
          ctl.push_front = accept && (in_kind == dqe_pkg::KIND_PUSH_FRONT);
          ctl.push_back  = accept && (in_kind == dqe_pkg::KIND_PUSH_BACK);
          cnt_nxt        = cnt_r + CNT_W'(1);
        end
      end
      dqe_pkg::KIND_POP_FRONT,
      dqe_pkg::KIND_POP_BACK: begin
        if (empty) begin
          status = dqe_pkg::ST_EMPTY;
        end else begin
          ctl.pop_front = accept && (in_kind == dqe_pkg::KIND_POP_FRONT);
          ctl.pop_back  = accept && (in_kind == dqe_pkg::KIND_POP_BACK);
          cnt_nxt       = cnt_r - CNT_W'(1);
          pop_word      = (in_kind == dqe_pkg::KIND_POP_FRONT) ? cell_data[0] : back_word;
        end
      end
      default: begin
        status = dqe_pkg::ST_DONE;
      end
    endcase
    pop_nxt = dqe_pkg::VALUE_W'($signed(pop_word));
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data, r_data;
    logic                  l_valid, r_valid;
    if (g == 0) begin : g_head
      assign l_data  = word;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end
    if (g == DEPTH - 1) begin : g_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
    end
    dqe_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .word_in    (word),
      .left_data  (l_data),
      .left_valid (l_valid),
      .right_data (r_data),
      .right_valid(r_valid),
      .data       (cell_data[g]),
      .valid      (cell_valid[g]),
      .tail_data  (cell_tail[g])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
    if (accept) begin
      pop_r    <= pop_nxt;
      status_r <= status;
      fill_r   <= dqe_pkg::FILL_W'(cnt_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = pop_r;
  assign out_status       = status_r;
  assign out_fill_count   = fill_r;

endmodule
`default_nettype wire

// ===== sv/dqe_cell.sv =====
`default_nettype none
module dqe_cell #(
  parameter int DATA_WIDTH = dqe_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dqe_pkg::cell_ctl_t    ctl,
  input  wire logic [DATA_WIDTH-1:0] word_in,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic                  left_valid,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  input  wire logic                  right_valid,
  output logic      [DATA_WIDTH-1:0] data,
  output logic                       valid,
  output logic      [DATA_WIDTH-1:0] tail_data
);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  valid_r, valid_nxt;
  logic                  is_tail;

  assign is_tail = valid_r && !right_valid;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctl.push_back) begin
      // first empty cell takes the word
      if (!valid_r && left_valid) begin
        data_nxt  = word_in;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctl.pop_back) begin
      if (is_tail) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data      = data_r;
  assign valid     = valid_r;
  assign tail_data = is_tail ? data_r : '0;

endmodule
`default_nettype wire
